>>> rtl/mfrc_pkg.sv
// ----------------------------------------------------------------------------
// mfrc_pkg
// Shared types, constants and the CRC-16/MODBUS byte update for the frame
// range calibrator.
// ----------------------------------------------------------------------------
package mfrc_pkg;

	// Frame and channel geometry
	localparam int NUM_CH          = 4;
	localparam int MAX_FRAME_BYTES = 64;
	localparam int QUEUE_DEPTH     = 4;

	// Field widths
	localparam int BYTE_W   = 8;
	localparam int RAW_W    = 32;
	localparam int GAIN_W   = 24;
	localparam int OFFSET_W = 32;
	localparam int RANGE_W  = 40;
	localparam int PROD_W   = GAIN_W + 1 + RAW_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// CRC-16/MODBUS, reflected form of 0x8005
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY_REFL = 16'hA001;

	// Rounding constant: one half at 16 dropped fraction bits
	localparam logic [15:0] ROUND_HALF = 16'h8000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH3   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH0 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH1 = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH2 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_OFFSET_CH3 = 3'd7;

	// Calibration defaults
	localparam logic [GAIN_W-1:0] GAIN_CH0_RST = 24'd1282379;
	localparam logic [GAIN_W-1:0] GAIN_CH1_RST = 24'd1311066;
	localparam logic [GAIN_W-1:0] GAIN_CH2_RST = 24'd1300550;
	localparam logic [GAIN_W-1:0] GAIN_CH3_RST = 24'd1313646;
	localparam logic [OFFSET_W-1:0] OFFSET_CH0_RST = 32'd40308;
	localparam logic [OFFSET_W-1:0] OFFSET_CH1_RST = 32'd40934;
	localparam logic [OFFSET_W-1:0] OFFSET_CH2_RST = 32'd39764;
	localparam logic [OFFSET_W-1:0] OFFSET_CH3_RST = 32'd43576;

	// One finished frame as handed from front to back
	typedef struct packed {
		logic                         crc_ok;
		logic [NUM_CH-1:0][RAW_W-1:0] raw;
	} frame_rec_t;

	// Fold one byte into the CRC, one bit per step
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY_REFL;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> rtl/mfrc_front.sv
// ----------------------------------------------------------------------------
// mfrc_front
// Byte front end: runs the CRC over all but the last two bytes, captures the
// four big-endian raw counts and posts one record per frame into the queue.
// ----------------------------------------------------------------------------
module mfrc_front #(
	parameter int MAX_FRAME_BYTES = mfrc_pkg::MAX_FRAME_BYTES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  logic [7:0]            rx_byte,
	input  logic                  frame_end,
	output logic                  rec_push,
	output mfrc_pkg::frame_rec_t  rec_data,
	input  logic                  rec_full
);

	localparam int POS_W = $clog2(MAX_FRAME_BYTES + 1);
	localparam int NC = mfrc_pkg::NUM_CH;
	localparam int RW = mfrc_pkg::RAW_W;

	logic [15:0]              crc_q;
	logic [POS_W-1:0]         pos_q;
	logic [7:0]               held0_q;
	logic [7:0]               held1_q;
	logic [NC-1:0][RW-1:0]    raw_q;

	logic                     accept;
	logic [15:0]              crc_nxt;
	logic [NC-1:0][RW-1:0]    raw_nxt;
	logic [POS_W-1:0]         pos_nxt;
	logic [3:0]               k;
	logic                     in_count;

	assign byte_ready = !rec_full;
	assign accept     = byte_valid && byte_ready;

	// Next CRC, position and counts for the byte on the bus
	always_comb begin
		crc_nxt  = (pos_q >= POS_W'(2)) ? mfrc_pkg::crc_byte(crc_q, held0_q) : crc_q;
		in_count = (pos_q >= POS_W'(1)) && (pos_q <= POS_W'(16));
		k        = 4'(pos_q - POS_W'(1));
		raw_nxt  = raw_q;
		if (in_count) begin
			raw_nxt[k[3:2]][{~k[1:0], 3'b000} +: 8] = rx_byte;
		end
		pos_nxt = (pos_q < POS_W'(MAX_FRAME_BYTES)) ? pos_q + POS_W'(1) : pos_q;
	end

	// Frame end: trailing bytes arrive low byte first
	assign rec_push        = accept && frame_end;
	assign rec_data.crc_ok = (crc_nxt == {rx_byte, held1_q});
	assign rec_data.raw    = raw_nxt;

	// Advance frame state, clear it after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q   <= mfrc_pkg::CRC_INIT;
			pos_q   <= '0;
			held0_q <= '0;
			held1_q <= '0;
			raw_q   <= '0;
		end else if (accept) begin
			if (frame_end) begin
				crc_q   <= mfrc_pkg::CRC_INIT;
				pos_q   <= '0;
				held0_q <= '0;
				held1_q <= '0;
				raw_q   <= '0;
			end else begin
				crc_q   <= crc_nxt;
				pos_q   <= pos_nxt;
				held0_q <= held1_q;
				held1_q <= rx_byte;
				raw_q   <= raw_nxt;
			end
		end
	end

endmodule

>>> rtl/mfrc_queue.sv
// ----------------------------------------------------------------------------
// mfrc_queue
// Short first-in first-out buffer of frame records between front and back.
// ----------------------------------------------------------------------------
module mfrc_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mfrc_pkg::frame_rec_t  push_data,
	output logic                  full,
	input  logic                  pop,
	output mfrc_pkg::frame_rec_t  head,
	output logic                  not_empty
);

	localparam int DEPTH = mfrc_pkg::QUEUE_DEPTH;
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	mfrc_pkg::frame_rec_t  mem_q [DEPTH];
	logic [PTR_W-1:0]      wr_ptr_q;
	logic [PTR_W-1:0]      rd_ptr_q;
	logic [CNT_W-1:0]      count_q;

	assign full      = (count_q == CNT_W'(DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];

	// Store a record
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	// Move pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push) else $error("record pushed into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("record popped from empty queue");
	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue occupancy lost a record");
`endif

endmodule

>>> rtl/mfrc_back.sv
// ----------------------------------------------------------------------------
// mfrc_back
// Calibration back end: holds gains and offsets, multiplies each raw count by
// its gain, rounds away the low 16 product bits, adds the offset and saturates.
// ----------------------------------------------------------------------------
module mfrc_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [mfrc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mfrc_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                rec_avail,
	input  mfrc_pkg::frame_rec_t                rec_data,
	output logic                                rec_pop,
	output logic                                res_valid,
	input  logic                                res_ready,
	output logic                                res_crc_ok,
	output logic [mfrc_pkg::NUM_CH*mfrc_pkg::RANGE_W-1:0] res_ranges
);

	localparam int NC  = mfrc_pkg::NUM_CH;
	localparam int PW  = mfrc_pkg::PROD_W;
	localparam int RW  = mfrc_pkg::RANGE_W;
	localparam int OW  = mfrc_pkg::OFFSET_W;
	localparam int GW  = mfrc_pkg::GAIN_W;
	localparam int SW  = RW + 3;

	logic [GW-1:0]                gain_q   [NC];
	logic [OW-1:0]                offset_q [NC];

	logic                         v_s1;
	logic                         crc_ok_s1;
	logic signed [PW-1:0]         prod_s1 [NC];

	logic                         out_valid_q;
	logic                         crc_ok_q;
	logic [NC-1:0][RW-1:0]        range_q;

	logic                         advance;
	logic                         load_s1;
	logic signed [PW-1:0]         prod    [NC];
	logic [NC-1:0][RW-1:0]        range_nxt;
	logic signed [PW:0]           rnd     [NC];
	logic signed [SW-1:0]         sum     [NC];

	assign advance = !out_valid_q || res_ready;
	assign load_s1 = !v_s1 || advance;
	assign rec_pop = rec_avail && load_s1;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q[0]   <= mfrc_pkg::GAIN_CH0_RST;
			gain_q[1]   <= mfrc_pkg::GAIN_CH1_RST;
			gain_q[2]   <= mfrc_pkg::GAIN_CH2_RST;
			gain_q[3]   <= mfrc_pkg::GAIN_CH3_RST;
			offset_q[0] <= mfrc_pkg::OFFSET_CH0_RST;
			offset_q[1] <= mfrc_pkg::OFFSET_CH1_RST;
			offset_q[2] <= mfrc_pkg::OFFSET_CH2_RST;
			offset_q[3] <= mfrc_pkg::OFFSET_CH3_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mfrc_pkg::REG_GAIN_CH0:   gain_q[0]   <= cfg_data[GW-1:0];
				mfrc_pkg::REG_GAIN_CH1:   gain_q[1]   <= cfg_data[GW-1:0];
				mfrc_pkg::REG_GAIN_CH2:   gain_q[2]   <= cfg_data[GW-1:0];
				mfrc_pkg::REG_GAIN_CH3:   gain_q[3]   <= cfg_data[GW-1:0];
				mfrc_pkg::REG_OFFSET_CH0: offset_q[0] <= cfg_data[OW-1:0];
				mfrc_pkg::REG_OFFSET_CH1: offset_q[1] <= cfg_data[OW-1:0];
				mfrc_pkg::REG_OFFSET_CH2: offset_q[2] <= cfg_data[OW-1:0];
				mfrc_pkg::REG_OFFSET_CH3: offset_q[3] <= cfg_data[OW-1:0];
				default: ;
			endcase
		end
	end

	// Stage 1: one multiplier per channel
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			prod[c] = $signed({1'b0, gain_q[c]}) * $signed(rec_data.raw[c]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (load_s1) begin
			v_s1 <= rec_avail;
		end
	end

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			crc_ok_s1 <= rec_data.crc_ok;
			for (int c = 0; c < NC; c++) begin
				prod_s1[c] <= prod[c];
			end
		end
	end

	// Stage 2: round half up, add offset, clamp to the range width
	always_comb begin
		for (int c = 0; c < NC; c++) begin
			rnd[c] = {prod_s1[c][PW-1], prod_s1[c]}
				+ $signed({{(PW-15){1'b0}}, mfrc_pkg::ROUND_HALF});
			sum[c] = SW'($signed(rnd[c][PW:16])) + SW'($signed(offset_q[c]));
			if (sum[c][SW-1:RW-1] == '0 || sum[c][SW-1:RW-1] == '1) begin
				range_nxt[c] = sum[c][RW-1:0];
			end else if (sum[c][SW-1]) begin
				range_nxt[c] = {1'b1, {(RW-1){1'b0}}};
			end else begin
				range_nxt[c] = {1'b0, {(RW-1){1'b1}}};
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && v_s1) begin
			crc_ok_q <= crc_ok_s1;
			range_q  <= range_nxt;
		end
	end

	assign res_valid  = out_valid_q;
	assign res_crc_ok = crc_ok_q;
	assign res_ranges = range_q;

`ifndef ASSERT_OFF
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && !load_s1) |=> v_s1) else $error("stage 1 result dropped");
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(out_valid_q) && out_valid_q) |-> $past(v_s1))
		else $error("result without stage 1 word");
	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		rec_pop |-> (!v_s1 || advance)) else $error("pop with stage 1 blocked");
`endif

endmodule

>>> rtl/modbus_frame_range_calibrator.sv
// ----------------------------------------------------------------------------
// modbus_frame_range_calibrator
// Checks the CRC-16/MODBUS of a sensor reply frame and turns its four raw
// counts into calibrated, saturated ranges.
// ----------------------------------------------------------------------------
// Throughput: one byte word per cycle while the record queue is not full;
// one result word per cycle at most. After the edge that takes the frame's
// last byte, its record passes the queue, multiplier stage and output register.
// A four-entry record queue lets the byte side run while results wait.
// Reset clears frame state and loads the default gains and offsets at once.
// ----------------------------------------------------------------------------
module modbus_frame_range_calibrator #(
	parameter int MAX_FRAME_BYTES = mfrc_pkg::MAX_FRAME_BYTES
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// byte stream
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [7:0]                            s_tdata,  // [7:0] rx_byte
	input  logic                                  s_tlast,  // frame_end
	// result stream
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [159:0]                          m_tdata,  // range_0..range_3, 40 bits each
	output logic                                  m_tuser,  // crc_ok
	// configuration
	input  logic                                  cfg_we,
	input  logic [mfrc_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mfrc_pkg::CFG_DATA_W-1:0]       cfg_data
);

	mfrc_pkg::frame_rec_t  push_rec;
	mfrc_pkg::frame_rec_t  head_rec;
	logic                  push;
	logic                  full;
	logic                  pop;
	logic                  not_empty;

	// Accept bytes and build frame records
	mfrc_front #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (s_tvalid),
		.byte_ready (s_tready),
		.rx_byte    (s_tdata),
		.frame_end  (s_tlast),
		.rec_push   (push),
		.rec_data   (push_rec),
		.rec_full   (full)
	);

	// Decouple byte side from calibration
	mfrc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_rec),
		.full      (full),
		.pop       (pop),
		.head      (head_rec),
		.not_empty (not_empty)
	);

	// Calibrate and present results
	mfrc_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.rec_avail  (not_empty),
		.rec_data   (head_rec),
		.rec_pop    (pop),
		.res_valid  (m_tvalid),
		.res_ready  (m_tready),
		.res_crc_ok (m_tuser),
		.res_ranges (m_tdata)
	);

endmodule
